[sv/utf8d_pkg.sv]
// utf8d_pkg: shared types and constants for the utf-8 stream decoder
// used by utf8d_core, utf8d_outq and utf8_stream_decoder; no dependencies
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int unsigned CpW      = 21;
  localparam int unsigned PartialW = 15;

  localparam logic [CpW-1:0] SubstChar = 21'h00003F;

  // lead byte patterns and payload masks
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Val  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Val  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Val  = 8'hF0;
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContVal   = 8'h80;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           is_error;
    logic           last;
  } result_t;

  // what one byte produces: zero, one or two results
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } decode_t;

endpackage

[sv/utf8d_core.sv]
// utf8d_core: sequence state and single-pass decode of one byte
// depends on utf8d_pkg
`timescale 1ns / 1ps

module utf8d_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  output utf8d_pkg::decode_t dec
);

  logic [1:0]                     pending_count;
  logic [1:0]                     pending_count_next;
  logic [utf8d_pkg::PartialW-1:0] partial_value;
  logic [utf8d_pkg::PartialW-1:0] partial_value_next;

  // fresh-start decode of the byte, used with no sequence open and to restart after an interrupted sequence
  logic                           st_emit;
  utf8d_pkg::result_t             st_res;
  logic [1:0]                     st_pend;
  logic [utf8d_pkg::PartialW-1:0] st_partial;
  logic [utf8d_pkg::CpW-1:0]      joined;
  logic [1:0]                     pend_dec;

  always_comb begin
    st_emit    = 1'b0;
    st_pend    = 2'd0;
    st_partial = '0;
    st_res     = '{code_point: utf8d_pkg::SubstChar, is_error: 1'b1, last: 1'b1};
    priority if (!data_byte[7]) begin
      st_emit = 1'b1;
      st_res  = '{code_point: {13'd0, data_byte}, is_error: 1'b0, last: 1'b1};
    end else if ((data_byte & utf8d_pkg::Lead2Mask) == utf8d_pkg::Lead2Val) begin
      st_pend    = 2'd1;
      st_partial = {10'd0, data_byte[4:0]};
    end else if ((data_byte & utf8d_pkg::Lead3Mask) == utf8d_pkg::Lead3Val) begin
      st_pend    = 2'd2;
      st_partial = {11'd0, data_byte[3:0]};
    end else if ((data_byte & utf8d_pkg::Lead4Mask) == utf8d_pkg::Lead4Val) begin
      st_pend    = 2'd3;
      st_partial = {12'd0, data_byte[2:0]};
    end else begin
      st_emit = 1'b1;
    end
  end

  // continuation merge
  assign joined   = {partial_value, data_byte[5:0]};
  assign pend_dec = pending_count - 2'd1;

  always_comb begin
    dec                = '0;
    pending_count_next = pending_count;
    partial_value_next = partial_value;
    priority if (pending_count == 2'd0) begin
      dec.count          = {1'b0, st_emit};
      dec.first          = st_res;
      pending_count_next = st_pend;
      partial_value_next = st_partial;
    end else if ((data_byte & utf8d_pkg::ContMask) == utf8d_pkg::ContVal) begin
      pending_count_next = pend_dec;
      if (pend_dec == 2'd0) begin
        dec.count          = 2'd1;
        dec.first          = '{code_point: joined, is_error: 1'b0, last: 1'b1};
        partial_value_next = '0;
      end else begin
        partial_value_next = joined[utf8d_pkg::PartialW-1:0];
      end
    end else begin
      // interrupted sequence: substitute, then restart on the same byte
      dec.first          = '{code_point: utf8d_pkg::SubstChar, is_error: 1'b1,
                             last: !st_emit};
      dec.second         = st_res;
      dec.count          = st_emit ? 2'd2 : 2'd1;
      pending_count_next = st_pend;
      partial_value_next = st_partial;
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= 2'd0;
      partial_value <= '0;
    end else if (accept) begin
      pending_count <= pending_count_next;
      partial_value <= partial_value_next;
    end
  end

endmodule

[sv/utf8d_outq.sv]
// utf8d_outq: four-entry result queue taking up to two results per cycle
// depends on utf8d_pkg
`timescale 1ns / 1ps

module utf8d_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  utf8d_pkg::decode_t dec,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output utf8d_pkg::result_t head
);

  utf8d_pkg::result_t mem [4];
  logic [1:0]         wr_ptr;
  logic [1:0]         wr_ptr_next;
  logic [1:0]         rd_ptr;
  logic [2:0]         count;
  logic [2:0]         count_next;
  logic [1:0]         n_push;
  logic               pop;

  assign n_push    = push ? dec.count : 2'd0;
  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 3'd0);
  // room for two results must be guaranteed before a byte is taken
  assign full      = (count > 3'd2);
  assign head      = mem[rd_ptr];

  assign wr_ptr_next = wr_ptr + n_push;
  assign count_next  = count + {1'b0, n_push} - {2'd0, pop};

  // storage writes
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= dec.first;
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr + 2'd1] <= dec.second;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
    end
  end

endmodule

[sv/utf8_stream_decoder.sv]
// utf8_stream_decoder: byte-serial utf-8 decoder, top level
// depends on utf8d_pkg, utf8d_core and utf8d_outq
`timescale 1ns / 1ps

// channel | direction | handshake            | payload
// input   | in        | in_valid / in_stall   | data_byte
// output  | out       | out_valid / out_stall | code_point, is_error, last
//
// one byte is taken per cycle while in_stall is low; its results land in the queue at the next edge
// and, with the queue empty, the first can be taken in the cycle after the byte was accepted
// the four-entry result queue sets the rate: a byte that gives two results fills
// two entries, and input stalls while the queue holds over two
// rst is synchronous and clears the open sequence and empties the queue
// out_stall only backs up the queue; decode state moves only on accepted beats

module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] code_point,
  output logic        is_error,
  output logic        last
);

  utf8d_pkg::decode_t dec;
  utf8d_pkg::result_t head;
  logic               accept;
  logic               full;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  // decode and sequence state
  utf8d_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .dec       (dec)
  );

  // result queue
  utf8d_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .dec       (dec),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign code_point = head.code_point;
  assign is_error   = head.is_error;
  assign last       = head.last;

endmodule
